@@ src/vcp_pkg.sv @@
`timescale 1ns / 1ps

package vcp_pkg;

    // axis that the shared multiplier and the divider work on
    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    typedef struct packed {
        logic  capture;
        logic  mac_en;
        axis_t axis;
        logic  clear;
    } acc_ctrl_t;

endpackage

@@ src/voxel_centroid_per_plane_unit.sv @@
`timescale 1ns / 1ps
// voxel that does not close a result: accept, then x, y, z multiply-accumulate
// steps on the one shared multiplier; in_ready is low while those steps run
// closing voxel: the same steps, then decide, D divisions and the output load, with
// D = 2 divisions per plane or 3 per volume on the one bit-serial divider (D = 0 on zero sum,
// or in plane mode on a negative sum); the output load waits while out_ready stalls
// reset (rst_n low, asynchronous) clears all sums, volume_mode and the output item

module voxel_centroid_per_plane_unit #(
    parameter int VALUE_BITS    = 16,
    parameter int INDEX_BITS    = 10,
    parameter int COUNT_BITS    = 20,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [2:0]                               paddr,
    input  logic [31:0]                              pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic signed [VALUE_BITS-1:0]             voxel_value,
    input  logic signed [INDEX_BITS-1:0]             col_index,
    input  logic signed [INDEX_BITS-1:0]             row_index,
    input  logic signed [INDEX_BITS-1:0]             plane_index,
    input  logic                                     last_in_plane,
    input  logic                                     last_in_volume,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic signed [INDEX_BITS+FRACTION_BITS-1:0] centroid_x,
    output logic signed [INDEX_BITS+FRACTION_BITS-1:0] centroid_y,
    output logic signed [INDEX_BITS+FRACTION_BITS-1:0] centroid_z,
    output logic signed [VALUE_BITS+COUNT_BITS-1:0]    weight,
    output logic                                     zero_sum
);
    import vcp_pkg::*;

    localparam int SUM_BITS      = VALUE_BITS + COUNT_BITS;
    localparam int MOMENT_BITS   = VALUE_BITS + INDEX_BITS + COUNT_BITS;
    localparam int CENTROID_BITS = INDEX_BITS + FRACTION_BITS;
    localparam logic REG_VOLUME_MODE = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_DECIDE,
        S_DIV_START,
        S_DIV_WAIT,
        S_OUT
    } state_t;

    state_t                     state_reg;
    axis_t                      axis_reg;
    logic                       closing_reg;
    logic                       mode_reg;
    logic [INDEX_BITS-1:0]      plane_reg;
    logic [CENTROID_BITS-1:0]   res_x_reg;
    logic [CENTROID_BITS-1:0]   res_y_reg;
    logic [CENTROID_BITS-1:0]   res_z_reg;
    logic [SUM_BITS-1:0]        res_w_reg;
    logic                       res_zero_reg;
    logic [CENTROID_BITS-1:0]   centroid_x_reg;
    logic [CENTROID_BITS-1:0]   centroid_y_reg;
    logic [CENTROID_BITS-1:0]   centroid_z_reg;
    logic [SUM_BITS-1:0]        weight_reg;
    logic                       zero_sum_reg;
    logic                       out_valid_reg;
    logic                       volume_mode_reg;

    acc_ctrl_t                  acc_ctrl;
    logic signed [SUM_BITS-1:0]    value_sum;
    logic signed [MOMENT_BITS-1:0] moment_x;
    logic signed [MOMENT_BITS-1:0] moment_y;
    logic signed [MOMENT_BITS-1:0] moment_z;
    logic signed [MOMENT_BITS-1:0] numer_sel;
    logic                          div_done;
    logic signed [CENTROID_BITS-1:0] div_quotient;

    logic                accept;
    logic                out_free;
    logic                cfg_write;
    logic [SUM_BITS-1:0] clamped_sum;
    logic [SUM_BITS-1:0] decide_w;
    logic                decide_zero;
    logic                last_axis;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_VOLUME_MODE) ? {31'b0, volume_mode_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_mode_reg <= 1'b0;
        end
        else if (cfg_write && paddr[2] == REG_VOLUME_MODE)
        begin
            volume_mode_reg <= pwdata[0];
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        acc_ctrl.capture = accept;
        acc_ctrl.mac_en  = (state_reg == S_ACC);
        acc_ctrl.axis    = axis_reg;
        acc_ctrl.clear   = (state_reg == S_OUT) && out_free;
    end

    vcp_accum #(
        .VALUE_BITS (VALUE_BITS),
        .INDEX_BITS (INDEX_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (acc_ctrl),
        .voxel_value (voxel_value),
        .col_index   (col_index),
        .row_index   (row_index),
        .plane_index (plane_index),
        .value_sum   (value_sum),
        .moment_x    (moment_x),
        .moment_y    (moment_y),
        .moment_z    (moment_z)
    );

    always_comb
    begin
        case (axis_reg)
            AXIS_X:  numer_sel = moment_x;
            AXIS_Y:  numer_sel = moment_y;
            default: numer_sel = moment_z;
        endcase
    end

    // in plane mode the clamped weight equals the sum whenever a division runs
    vcp_divider #(
        .NUM_BITS      (MOMENT_BITS),
        .DEN_BITS      (SUM_BITS),
        .FRACTION_BITS (FRACTION_BITS),
        .QUO_BITS      (CENTROID_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_DIV_START),
        .numer    (numer_sel),
        .denom    (value_sum),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign clamped_sum = value_sum[SUM_BITS-1] ? {SUM_BITS{1'b0}} : value_sum;
    assign decide_w    = mode_reg ? value_sum : clamped_sum;
    assign decide_zero = (decide_w == {SUM_BITS{1'b0}});
    assign last_axis   = mode_reg ? (axis_reg == AXIS_Z) : (axis_reg == AXIS_Y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            axis_reg       <= AXIS_X;
            closing_reg    <= 1'b0;
            mode_reg       <= 1'b0;
            plane_reg      <= '0;
            res_x_reg      <= '0;
            res_y_reg      <= '0;
            res_z_reg      <= '0;
            res_w_reg      <= '0;
            res_zero_reg   <= 1'b0;
            centroid_x_reg <= '0;
            centroid_y_reg <= '0;
            centroid_z_reg <= '0;
            weight_reg     <= '0;
            zero_sum_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // in S_OUT a taken item is replaced by the new one below
            if (out_valid_reg && out_ready && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        axis_reg    <= AXIS_X;
                        // in plane mode a volume end also closes a plane
                        closing_reg <= volume_mode_reg ? last_in_volume
                                                       : (last_in_plane || last_in_volume);
                        mode_reg    <= volume_mode_reg;
                        plane_reg   <= plane_index;
                        state_reg   <= S_ACC;
                    end
                end
                S_ACC:
                begin
                    case (axis_reg)
                        AXIS_X:  axis_reg <= AXIS_Y;
                        AXIS_Y:  axis_reg <= AXIS_Z;
                        default:
                        begin
                            axis_reg  <= AXIS_X;
                            state_reg <= closing_reg ? S_DECIDE : S_IDLE;
                        end
                    endcase
                end
                S_DECIDE:
                begin
                    res_w_reg    <= decide_w;
                    res_zero_reg <= decide_zero;
                    res_x_reg    <= '0;
                    res_y_reg    <= '0;
                    res_z_reg    <= mode_reg ? {CENTROID_BITS{1'b0}}
                                             : {plane_reg, {FRACTION_BITS{1'b0}}};
                    axis_reg     <= AXIS_X;
                    state_reg    <= decide_zero ? S_OUT : S_DIV_START;
                end
                S_DIV_START:
                begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        case (axis_reg)
                            AXIS_X:  res_x_reg <= div_quotient;
                            AXIS_Y:  res_y_reg <= div_quotient;
                            default: res_z_reg <= div_quotient;
                        endcase
                        if (last_axis)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            axis_reg  <= (axis_reg == AXIS_X) ? AXIS_Y : AXIS_Z;
                            state_reg <= S_DIV_START;
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        centroid_x_reg <= res_x_reg;
                        centroid_y_reg <= res_y_reg;
                        centroid_z_reg <= res_z_reg;
                        weight_reg     <= res_w_reg;
                        zero_sum_reg   <= res_zero_reg;
                        out_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign centroid_x = centroid_x_reg;
    assign centroid_y = centroid_y_reg;
    assign centroid_z = centroid_z_reg;
    assign weight     = weight_reg;
    assign zero_sum   = zero_sum_reg;

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV_WAIT)
        else $error("divider finished outside of the wait state");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("new item taken while the previous one is still accumulating");

    a_zero_centroid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && zero_sum_reg) |-> (centroid_x_reg == '0 && centroid_y_reg == '0))
        else $error("zero-sum item carries a nonzero centroid");

    a_clear_with_load: assert property (@(posedge clk) disable iff (!rst_n)
        acc_ctrl.clear |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("sums cleared without a result item being loaded");

endmodule

@@ src/vcp_accum.sv @@
`timescale 1ns / 1ps

module vcp_accum #(
    parameter int VALUE_BITS = 16,
    parameter int INDEX_BITS = 10,
    parameter int COUNT_BITS = 20
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  vcp_pkg::acc_ctrl_t                                  ctrl,
    input  logic signed [VALUE_BITS-1:0]                        voxel_value,
    input  logic signed [INDEX_BITS-1:0]                        col_index,
    input  logic signed [INDEX_BITS-1:0]                        row_index,
    input  logic signed [INDEX_BITS-1:0]                        plane_index,
    output logic signed [VALUE_BITS+COUNT_BITS-1:0]             value_sum,
    output logic signed [VALUE_BITS+INDEX_BITS+COUNT_BITS-1:0]  moment_x,
    output logic signed [VALUE_BITS+INDEX_BITS+COUNT_BITS-1:0]  moment_y,
    output logic signed [VALUE_BITS+INDEX_BITS+COUNT_BITS-1:0]  moment_z
);
    import vcp_pkg::*;

    localparam int SUM_BITS    = VALUE_BITS + COUNT_BITS;
    localparam int PROD_BITS   = VALUE_BITS + INDEX_BITS;
    localparam int MOMENT_BITS = VALUE_BITS + INDEX_BITS + COUNT_BITS;

    logic signed [VALUE_BITS-1:0]  val_reg;
    logic signed [INDEX_BITS-1:0]  col_reg;
    logic signed [INDEX_BITS-1:0]  row_reg;
    logic signed [INDEX_BITS-1:0]  plane_reg;
    logic signed [SUM_BITS-1:0]    sum_reg;
    logic signed [MOMENT_BITS-1:0] mx_reg;
    logic signed [MOMENT_BITS-1:0] my_reg;
    logic signed [MOMENT_BITS-1:0] mz_reg;

    logic signed [INDEX_BITS-1:0]  idx_sel;
    logic signed [MOMENT_BITS-1:0] moment_sel;
    logic signed [PROD_BITS-1:0]   product;
    logic signed [MOMENT_BITS-1:0] moment_next;
    logic signed [SUM_BITS-1:0]    sum_next;

    always_comb
    begin
        case (ctrl.axis)
            AXIS_X:
            begin
                idx_sel    = col_reg;
                moment_sel = mx_reg;
            end
            AXIS_Y:
            begin
                idx_sel    = row_reg;
                moment_sel = my_reg;
            end
            default:
            begin
                idx_sel    = plane_reg;
                moment_sel = mz_reg;
            end
        endcase
    end

    // one shared multiplier, one axis per cycle
    assign product     = val_reg * idx_sel;
    assign moment_next = moment_sel + {{COUNT_BITS{product[PROD_BITS-1]}}, product};
    assign sum_next    = sum_reg + {{COUNT_BITS{val_reg[VALUE_BITS-1]}}, val_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg   <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            plane_reg <= '0;
            sum_reg   <= '0;
            mx_reg    <= '0;
            my_reg    <= '0;
            mz_reg    <= '0;
        end
        else
        begin
            if (ctrl.capture)
            begin
                val_reg   <= voxel_value;
                col_reg   <= col_index;
                row_reg   <= row_index;
                plane_reg <= plane_index;
            end
            if (ctrl.clear)
            begin
                sum_reg <= '0;
                mx_reg  <= '0;
                my_reg  <= '0;
                mz_reg  <= '0;
            end
            else if (ctrl.mac_en)
            begin
                case (ctrl.axis)
                    AXIS_X:
                    begin
                        mx_reg  <= moment_next;
                        sum_reg <= sum_next;
                    end
                    AXIS_Y:  my_reg <= moment_next;
                    default: mz_reg <= moment_next;
                endcase
            end
        end
    end

    assign value_sum = sum_reg;
    assign moment_x  = mx_reg;
    assign moment_y  = my_reg;
    assign moment_z  = mz_reg;

endmodule

@@ src/vcp_divider.sv @@
`timescale 1ns / 1ps

module vcp_divider #(
    parameter int NUM_BITS      = 46,
    parameter int DEN_BITS      = 36,
    parameter int FRACTION_BITS = 16,
    parameter int QUO_BITS      = 26
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [NUM_BITS-1:0] numer,
    input  logic signed [DEN_BITS-1:0] denom,
    output logic                       done,
    output logic signed [QUO_BITS-1:0] quotient
);
    localparam int DIV_BITS = NUM_BITS + FRACTION_BITS;
    localparam int CNT_BITS = $clog2(DIV_BITS + 1);
    localparam logic [DIV_BITS-1:0] LIM_POS =
        {{(DIV_BITS-QUO_BITS+1){1'b0}}, {(QUO_BITS-1){1'b1}}};
    localparam logic [DIV_BITS-1:0] LIM_NEG = LIM_POS + {{(DIV_BITS-1){1'b0}}, 1'b1};

    logic [DIV_BITS-1:0] work_reg;
    logic [DEN_BITS-1:0] rem_reg;
    logic [DEN_BITS-1:0] den_reg;
    logic                neg_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                busy_reg;
    logic                fin_reg;
    logic                done_reg;
    logic [QUO_BITS-1:0] quo_reg;

    logic [NUM_BITS-1:0] num_u;
    logic [DEN_BITS-1:0] den_u;
    logic [NUM_BITS-1:0] num_mag;
    logic [DEN_BITS-1:0] den_mag;
    logic [DEN_BITS:0]   rem_shift;
    logic [DEN_BITS+1:0] diff;
    logic                fits;
    logic [DIV_BITS-1:0] limit;
    logic [QUO_BITS-1:0] quo_mag;

    assign num_u   = numer;
    assign den_u   = denom;
    assign num_mag = num_u[NUM_BITS-1] ? (~num_u + {{(NUM_BITS-1){1'b0}}, 1'b1}) : num_u;
    assign den_mag = den_u[DEN_BITS-1] ? (~den_u + {{(DEN_BITS-1){1'b0}}, 1'b1}) : den_u;

    // restoring step: one quotient bit a cycle
    assign rem_shift = {rem_reg, work_reg[DIV_BITS-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, den_reg};
    assign fits      = !diff[DEN_BITS+1];

    assign limit   = neg_reg ? LIM_NEG : LIM_POS;
    assign quo_mag = (work_reg > limit) ? limit[QUO_BITS-1:0] : work_reg[QUO_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg  <= '0;
            rem_reg   <= '0;
            den_reg   <= '0;
            neg_reg   <= 1'b0;
            count_reg <= '0;
            busy_reg  <= 1'b0;
            fin_reg   <= 1'b0;
            done_reg  <= 1'b0;
            quo_reg   <= '0;
        end
        else
        begin
            // fin and busy are never high together
            done_reg <= fin_reg;
            if (start && !busy_reg && !fin_reg)
            begin
                work_reg  <= {num_mag, {FRACTION_BITS{1'b0}}};
                rem_reg   <= '0;
                den_reg   <= den_mag;
                neg_reg   <= num_u[NUM_BITS-1] ^ den_u[DEN_BITS-1];
                count_reg <= CNT_BITS'(DIV_BITS);
                busy_reg  <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg   <= fits ? diff[DEN_BITS-1:0] : rem_shift[DEN_BITS-1:0];
                work_reg  <= {work_reg[DIV_BITS-2:0], fits};
                count_reg <= count_reg - {{(CNT_BITS-1){1'b0}}, 1'b1};
                if (count_reg == {{(CNT_BITS-1){1'b0}}, 1'b1})
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                // saturate, then apply the sign
                quo_reg  <= neg_reg ? (~quo_mag + {{(QUO_BITS-1){1'b0}}, 1'b1}) : quo_mag;
                fin_reg  <= 1'b0;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
